/* hw/rtl/sha1_message_digest_assert.svh */
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define SMD_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define SMD_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/smd_pkg.sv */
package smd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      LOAD_NONE,
      LOAD_BYTE,
      LOAD_PAD
   } load_type;

   typedef struct packed {
      load_type   load;
      logic       start_rounds;
      logic       round_step;
      logic       fold;
      logic       emit_step;
      logic       msg_clear;
   } cmd_type;

   typedef struct packed {
      logic       chunk_full;
      logic       pad_done;
      logic       rounds_done;
      logic       emit_last;
   } status_type;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [6:0]  LAST_ROUND = 7'd79;
   localparam logic [5:0]  LEN_POS = 6'd56;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'h0, nib};
      end else begin
         ch = 8'h37 + {4'h0, nib};
      end
      return ch;
   endfunction

endpackage

/* hw/rtl/smd_if.sv */
interface smd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_present;
   logic       end_of_message;
   modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface smd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] digest_byte;
   logic       digest_last;
   modport source (output valid, digest_byte, digest_last, input ready);
   modport sink   (input valid, digest_byte, digest_last, output ready);
endinterface

interface smd_csr_if;
   logic valid;
   logic ready;
   logic hex_output;
   modport source (output valid, hex_output, input ready);
   modport sink   (input valid, hex_output, output ready);
endinterface

/* hw/rtl/smd_datapath.sv */
module smd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  smd_pkg::cmd_type    cmd,
   input  logic [7:0]          in_byte,
   input  logic                hex_mode,
   output smd_pkg::status_type status,
   output logic [7:0]          out_byte
);
   import smd_pkg::*;

   logic [31:0] w_ff [16];
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [60:0] count_ff;
   logic [5:0]  pos_ff;
   logic [6:0]  round_ff;
   logic [5:0]  emit_ff;
   logic        second_ff;
   logic        pad_done_ff;
   logic        pad_two;
   logic [31:0] f_val, k_val, wi, wnew, t_val;
   logic [7:0]  load_val;
   logic [63:0] bits;
   logic [31:0] sel_word;
   logic [2:0]  widx;

   assign bits = {count_ff, 3'b000};

   // pad_two: the marker byte did not leave room for the length in this chunk.
   assign pad_two = !second_ff && (count_ff[5:0] >= LEN_POS);

   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) ^ (~b_ff & d_ff);
         k_val = K0;
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) ^ (b_ff & d_ff) ^ (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
      wnew = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      wnew = {wnew[30:0], wnew[31]};
      wi = (round_ff < 7'd16) ? w_ff[0] : wnew;
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + wi;
   end

   always_comb begin
      load_val = (cmd.load == LOAD_BYTE) ? in_byte : 8'h00;
      if (cmd.load == LOAD_PAD && pos_ff == count_ff[5:0] && !second_ff) begin
         load_val = PAD_BYTE;
      end
      if (cmd.load == LOAD_PAD && pos_ff >= LEN_POS && !pad_two) begin
         load_val = bits[8'd63 - {2'b00, pos_ff - LEN_POS, 3'b000} -: 8];
      end
   end

   // Window rotates by one word each round, so w_ff[0] is round word i for rounds below 16 and word i-16 after that.
   always_ff @(posedge clock) begin
      if (cmd.load != LOAD_NONE) begin
         w_ff[pos_ff[5:2]] <= {w_ff[pos_ff[5:2]][23:0], load_val};
      end else if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= wi;
      end
   end

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         h_in[i] = h_ff[i];
      end
      if (cmd.fold) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end
      if (cmd.msg_clear) begin
         h_in[0] = H0;
         h_in[1] = H1;
         h_in[2] = H2;
         h_in[3] = H3;
         h_in[4] = H4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0] <= H0;
         h_ff[1] <= H1;
         h_ff[2] <= H2;
         h_ff[3] <= H3;
         h_ff[4] <= H4;
         count_ff <= '0;
         pos_ff <= '0;
         round_ff <= '0;
         emit_ff <= '0;
         second_ff <= 1'b0;
         pad_done_ff <= 1'b0;
      end else begin
         h_ff <= h_in;
         if (cmd.load == LOAD_BYTE) begin
            count_ff <= count_ff + 61'd1;
         end
         if (cmd.load != LOAD_NONE) begin
            pos_ff <= pos_ff + 6'd1;
            if (pos_ff == 6'd63) begin
               second_ff <= second_ff | (cmd.load == LOAD_PAD);
               if (cmd.load == LOAD_PAD && !pad_two) begin
                  pad_done_ff <= 1'b1;
               end
            end
         end
         if (cmd.start_rounds) begin
            round_ff <= '0;
         end else if (cmd.round_step) begin
            round_ff <= round_ff + 7'd1;
         end
         if (cmd.emit_step) begin
            emit_ff <= status.emit_last ? 6'd0 : emit_ff + 6'd1;
         end
         if (cmd.msg_clear) begin
            count_ff <= '0;
            pos_ff <= '0;
            second_ff <= 1'b0;
            pad_done_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_rounds) begin
         a_ff <= h_ff[0];
         b_ff <= h_ff[1];
         c_ff <= h_ff[2];
         d_ff <= h_ff[3];
         e_ff <= h_ff[4];
      end else if (cmd.round_step) begin
         e_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff;
         a_ff <= t_val;
      end
   end

   // pad_done: the chunk carrying the length has been loaded.
   always_comb begin
      status.chunk_full = (pos_ff == 6'd63);
      status.pad_done = pad_done_ff;
      status.rounds_done = (round_ff == LAST_ROUND);
      status.emit_last = hex_mode ? (emit_ff == 6'd39) : (emit_ff == 6'd19);
      widx = hex_mode ? emit_ff[5:3] : 3'(emit_ff[4:2]);
      sel_word = h_ff[0];
      case (widx)
         3'd1:    sel_word = h_ff[1];
         3'd2:    sel_word = h_ff[2];
         3'd3:    sel_word = h_ff[3];
         3'd4:    sel_word = h_ff[4];
         default: sel_word = h_ff[0];
      endcase
      if (hex_mode) begin
         out_byte = hex_char(sel_word[5'd28 - {emit_ff[2:0], 2'b00} +: 4]);
      end else begin
         out_byte = sel_word[5'd24 - {emit_ff[1:0], 3'b000} +: 8];
      end
   end

endmodule

/* hw/rtl/smd_control.sv */
module smd_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                req_present,
   input  logic                req_end,
   input  logic                out_free,
   input  smd_pkg::status_type status,
   output smd_pkg::cmd_type    cmd,
   output logic                req_ready,
   output logic                emit_valid,
   output logic                csr_ready
);
   import smd_pkg::*;

   state_type state_ff, state_in;
   logic      final_ff, final_in;

   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               final_in = req_end;
               if (req_present && status.chunk_full) begin
                  state_in = ST_ROUND;
               end else if (req_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (status.chunk_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (status.rounds_done) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!final_ff) begin
               state_in = ST_IDLE;
            end else if (!status.pad_done) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && status.emit_last) begin
               state_in = ST_IDLE;
               final_in = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.load = LOAD_NONE;
      req_ready = 1'b0;
      emit_valid = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            csr_ready = 1'b1;
            if (req_fire && req_present) begin
               cmd.load = LOAD_BYTE;
            end
            cmd.start_rounds = req_fire && req_present && status.chunk_full;
         end
         ST_PAD: begin
            cmd.load = LOAD_PAD;
            cmd.start_rounds = status.chunk_full;
         end
         ST_ROUND: cmd.round_step = 1'b1;
         ST_FOLD: cmd.fold = 1'b1;
         ST_EMIT: begin
            emit_valid = 1'b1;
            cmd.emit_step = out_free;
            cmd.msg_clear = out_free && status.emit_last;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
      end
   end

   `include "sha1_message_digest_assert.svh"
   `SMD_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE, "ready outside idle")
   `SMD_ASSERT_NEXT(a_round_fold, clock, reset, state_ff == ST_ROUND && status.rounds_done, state_ff == ST_FOLD, "rounds did not fold")
   `SMD_ASSERT_IMPL(a_emit_only, clock, reset, emit_valid, state_ff == ST_EMIT && final_ff, "emit without end")

endmodule

/* hw/rtl/sha1_message_digest.sv */
// SHA-1 hasher taking one message byte per item; an item with end_of_message closes the
// message and the block then returns 20 digest bytes (or 40 uppercase hex characters).
// Each data byte is loaded as it is taken, except that the byte closing each 64-byte chunk
// also starts the 80 rounds, run one per cycle on a single round unit, and then a fold of
// the result into the hash state. Closing a message adds a padding pass that fills the rest
// of the chunk one byte per cycle, followed by rounds and fold, once or twice, before the
// digest streams out, one item per cycle unless the receiver holds off rsp.ready.
// Requests and register writes are taken only while no chunk is in work.
module sha1_message_digest (
   input logic      clock,
   input logic      reset,
   smd_req_if.sink  req,
   smd_rsp_if.source rsp,
   smd_csr_if.sink  csr
);
   import smd_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       hex_ff;
   logic       emit_valid;
   logic [7:0] emit_byte;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_free;
   logic       req_ready;
   logic       csr_ready;

   assign out_free = !out_valid_ff || rsp.ready;
   assign req.ready = req_ready;
   assign csr.ready = csr_ready;

   smd_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req.valid && req_ready),
      .req_present (req.byte_present),
      .req_end     (req.end_of_message),
      .out_free    (out_free),
      .status      (status),
      .cmd         (cmd),
      .req_ready   (req_ready),
      .emit_valid  (emit_valid),
      .csr_ready   (csr_ready)
   );

   smd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .in_byte  (req.msg_byte),
      .hex_mode (hex_ff),
      .status   (status),
      .out_byte (emit_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr.valid && csr_ready) begin
            hex_ff <= csr.hex_output;
         end
         if (out_free) begin
            out_valid_ff <= emit_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit_valid) begin
         out_byte_ff <= emit_byte;
         out_last_ff <= status.emit_last;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.digest_byte = out_byte_ff;
   assign rsp.digest_last = out_last_ff;

endmodule
